// ----- sv/valve_step_positioner_assert.svh -----
// assertion macros used by the checker file vsp_checker.sv
`ifndef VALVE_STEP_POSITIONER_ASSERT_SVH
`define VALVE_STEP_POSITIONER_ASSERT_SVH

// condition implies consequence in the same cycle
`define VSP_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("valve_step_positioner: same-cycle check failed");

// condition implies consequence in the next cycle
`define VSP_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("valve_step_positioner: next-cycle check failed");

`endif

// ----- sv/vsp_pkg.sv -----
// ----------------------------------------------------------------------------
// vsp_pkg
// Types, register indexes and reset values of the valve step positioner.
// ----------------------------------------------------------------------------
package vsp_pkg;

  localparam int POSITION_WIDTH_DEFAULT = 16;
  localparam int TIME_WIDTH_DEFAULT     = 16;
  localparam int CFG_INDEX_WIDTH        = 3;
  localparam int CFG_DATA_WIDTH         = 16;
  localparam int PULSE_WIDTH            = 17;

  typedef enum logic [1:0] {
    PH_HOLD = 2'd0,
    PH_UP   = 2'd1,
    PH_DOWN = 2'd2
  } phase_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_HOLD_TIME       = 3'd0,
    REG_UP_MIN_STEP     = 3'd1,
    REG_UP_MAX_STEP     = 3'd2,
    REG_DOWN_MIN_STEP   = 3'd3,
    REG_DOWN_MAX_STEP   = 3'd4,
    REG_UP_EXTRA_TIME   = 3'd5,
    REG_DOWN_EXTRA_TIME = 3'd6,
    REG_MOTOR_MODE      = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [15:0] hold_time;
    logic [15:0] up_min_step;
    logic [15:0] up_max_step;
    logic [15:0] down_min_step;
    logic [15:0] down_max_step;
    logic [15:0] up_extra_time;
    logic [15:0] down_extra_time;
    logic        motor_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    hold_time:       16'd400,
    up_min_step:     16'd50,
    up_max_step:     16'd400,
    down_min_step:   16'd50,
    down_max_step:   16'd400,
    up_extra_time:   16'd30,
    down_extra_time: 16'd30,
    motor_mode:      1'b0
  };

  localparam logic [PULSE_WIDTH-1:0] PULSE_RESET = 17'd400;

  typedef struct packed {
    logic [15:0] demand_position;
    logic        pressure_low;
    logic        startup_inhibit;
  } item_t;

  typedef struct packed {
    logic        open_enable;
    logic        close_enable;
    logic [1:0]  phase_now;
    logic [15:0] position_now;
    logic        demand_reset;
  } result_t;

endpackage

// ----- sv/vsp_step.sv -----
// ----------------------------------------------------------------------------
// vsp_step
// One tick of the positioner: phase decision, clamped step, pulse length,
// position update and enable pair.
// ----------------------------------------------------------------------------
module vsp_step #(
  parameter int POSITION_WIDTH = vsp_pkg::POSITION_WIDTH_DEFAULT,
  parameter int TIME_WIDTH     = vsp_pkg::TIME_WIDTH_DEFAULT
) (
  input  vsp_pkg::cfg_t                         cfg,
  input  vsp_pkg::item_t                        item,
  input  vsp_pkg::phase_t                       phase,
  input  logic [TIME_WIDTH-1:0]                 elapsed_ticks,
  input  logic [vsp_pkg::PULSE_WIDTH-1:0]       pulse_length,
  input  logic [POSITION_WIDTH-1:0]             position,
  output vsp_pkg::phase_t                       phase_next,
  output logic [TIME_WIDTH-1:0]                 elapsed_ticks_next,
  output logic [vsp_pkg::PULSE_WIDTH-1:0]       pulse_length_next,
  output logic [POSITION_WIDTH-1:0]             position_next,
  output vsp_pkg::result_t                      result
);

  localparam int DW = (POSITION_WIDTH > 16) ? POSITION_WIDTH : 16;
  localparam int LW = (TIME_WIDTH > vsp_pkg::PULSE_WIDTH) ? TIME_WIDTH : vsp_pkg::PULSE_WIDTH;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  logic [DW-1:0]             raw_w, demand_w, position_w;
  logic [DW-1:0]             up_diff, down_diff, up_step, down_step;
  logic [POSITION_WIDTH-1:0] demand;
  logic [TIME_WIDTH-1:0]     e;
  logic [LW-1:0]             e_w, time_max_w, hold_len, pulse_len;
  logic                      hold_over, pulse_over, up_go, down_go;
  logic                      changed, refused;

  assign raw_w      = DW'(item.demand_position);
  assign demand     = raw_w[POSITION_WIDTH-1:0];
  assign demand_w   = DW'(demand);
  assign position_w = DW'(position);

  assign up_diff   = demand_w - position_w;
  assign down_diff = position_w - demand_w;
  assign up_go     = (demand_w > position_w) && (up_diff > DW'(cfg.up_min_step));
  assign down_go   = (position_w > demand_w) && (down_diff > DW'(cfg.down_min_step));
  assign up_step   = (up_diff > DW'(cfg.up_max_step)) ? DW'(cfg.up_max_step) : up_diff;
  assign down_step = (down_diff > DW'(cfg.down_max_step)) ? DW'(cfg.down_max_step)
                                                           : down_diff;

  // saturating tick counter
  assign e          = elapsed_ticks + TIME_WIDTH'(elapsed_ticks != TIME_MAX);
  assign e_w        = LW'(e);
  assign time_max_w = LW'(TIME_MAX);
  assign hold_len   = (LW'(cfg.hold_time) > time_max_w) ? time_max_w : LW'(cfg.hold_time);
  assign pulse_len  = (LW'(pulse_length) > time_max_w) ? time_max_w : LW'(pulse_length);
  assign hold_over  = e_w >= hold_len;
  assign pulse_over = e_w >= pulse_len;

  always_comb begin
    phase_next        = phase;
    pulse_length_next = pulse_length;
    position_next     = position;
    changed           = 1'b0;
    refused           = 1'b0;
    if (item.startup_inhibit) begin
      phase_next = vsp_pkg::PH_DOWN;
    end else begin
      unique case (phase)
        vsp_pkg::PH_HOLD: begin
          if (hold_over) begin
            if (up_go) begin
              if (item.pressure_low) begin
                refused = 1'b1;
              end else begin
                phase_next        = vsp_pkg::PH_UP;
                changed           = 1'b1;
                pulse_length_next = vsp_pkg::PULSE_WIDTH'(up_step[15:0])
                                  + vsp_pkg::PULSE_WIDTH'(cfg.up_extra_time);
                position_next     = position + up_step[POSITION_WIDTH-1:0];
              end
            end else if (down_go) begin
              phase_next        = vsp_pkg::PH_DOWN;
              changed           = 1'b1;
              pulse_length_next = vsp_pkg::PULSE_WIDTH'(down_step[15:0])
                                + vsp_pkg::PULSE_WIDTH'(cfg.down_extra_time);
              position_next     = position - down_step[POSITION_WIDTH-1:0];
            end
          end
        end
        vsp_pkg::PH_UP, vsp_pkg::PH_DOWN: begin
          if (pulse_over) begin
            phase_next = vsp_pkg::PH_HOLD;
            changed    = 1'b1;
          end
        end
        default: begin
          phase_next = vsp_pkg::PH_HOLD;
          changed    = 1'b1;
        end
      endcase
    end
  end

  assign elapsed_ticks_next = changed ? '0 : e;

  always_comb begin
    if (cfg.motor_mode) begin
      result.open_enable  = (phase_next == vsp_pkg::PH_UP);
      result.close_enable = (phase_next == vsp_pkg::PH_DOWN);
    end else begin
      result.open_enable  = (phase_next != vsp_pkg::PH_DOWN);
      result.close_enable = (phase_next == vsp_pkg::PH_UP);
    end
    result.phase_now    = phase_next;
    result.position_now = 16'(position_next);
    result.demand_reset = refused;
  end

endmodule

// ----- sv/valve_step_positioner.sv -----
// ----------------------------------------------------------------------------
// valve_step_positioner
// Stepping valve positioner, one transaction per millisecond tick.
// ----------------------------------------------------------------------------
// Each tick transaction is captured in an input register and, in the cycle it
// leaves that register, updates the phase, tick counter, pulse length and
// position estimate and loads the result register. A tick leaves the input
// register as soon as the result register is empty or being taken, so a
// result-side stall holds it there. One tick is taken every cycle as long as
// the result side keeps up; the rate is set by the combinational state update
// between the input register and the result register. Configuration writes
// apply at once and are meant to happen only while no tick is in flight.
module valve_step_positioner #(
  parameter int POSITION_WIDTH = vsp_pkg::POSITION_WIDTH_DEFAULT,
  parameter int TIME_WIDTH     = vsp_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  vsp_pkg::item_t                         item,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output vsp_pkg::result_t                       result,
  input  logic                                   cfg_write,
  input  logic [vsp_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [vsp_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

  vsp_pkg::cfg_t                      cfg;
  vsp_pkg::item_t                     item_reg;
  logic                               item_reg_valid;
  logic                               advance;

  vsp_pkg::phase_t                    phase, phase_next;
  logic [TIME_WIDTH-1:0]              elapsed_ticks, elapsed_ticks_next;
  logic [vsp_pkg::PULSE_WIDTH-1:0]    pulse_length, pulse_length_next;
  logic [POSITION_WIDTH-1:0]          position, position_next;
  vsp_pkg::result_t                   result_next;

  assign advance    = item_reg_valid && (!result_valid || !result_stall);
  assign item_stall = item_reg_valid && result_valid && result_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= vsp_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (vsp_pkg::reg_index_t'(cfg_index))
        vsp_pkg::REG_HOLD_TIME:       cfg.hold_time       <= cfg_data;
        vsp_pkg::REG_UP_MIN_STEP:     cfg.up_min_step     <= cfg_data;
        vsp_pkg::REG_UP_MAX_STEP:     cfg.up_max_step     <= cfg_data;
        vsp_pkg::REG_DOWN_MIN_STEP:   cfg.down_min_step   <= cfg_data;
        vsp_pkg::REG_DOWN_MAX_STEP:   cfg.down_max_step   <= cfg_data;
        vsp_pkg::REG_UP_EXTRA_TIME:   cfg.up_extra_time   <= cfg_data;
        vsp_pkg::REG_DOWN_EXTRA_TIME: cfg.down_extra_time <= cfg_data;
        vsp_pkg::REG_MOTOR_MODE:      cfg.motor_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_reg_valid <= 1'b1;
    end else if (advance) begin
      item_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_reg <= item;
    end
  end

  vsp_step #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .TIME_WIDTH     (TIME_WIDTH)
  ) u_step (
    .cfg                (cfg),
    .item               (item_reg),
    .phase              (phase),
    .elapsed_ticks      (elapsed_ticks),
    .pulse_length       (pulse_length),
    .position           (position),
    .phase_next         (phase_next),
    .elapsed_ticks_next (elapsed_ticks_next),
    .pulse_length_next  (pulse_length_next),
    .position_next      (position_next),
    .result             (result_next)
  );

  // positioner state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= vsp_pkg::PH_HOLD;
      elapsed_ticks <= '0;
      pulse_length  <= vsp_pkg::PULSE_RESET;
      position      <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      elapsed_ticks <= elapsed_ticks_next;
      pulse_length  <= pulse_length_next;
      position      <= position_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

// ----- sv/vsp_checker.sv -----
// ----------------------------------------------------------------------------
// vsp_checker
// Port-level checks of the valve step positioner, bound to the top level.
// ----------------------------------------------------------------------------
`include "valve_step_positioner_assert.svh"

module vsp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                item_valid,
  input logic                                item_stall,
  input vsp_pkg::item_t                      item,
  input logic                                result_valid,
  input logic                                result_stall,
  input vsp_pkg::result_t                    result
);

  logic is_hold, is_up, is_down, both_on;

  assign is_hold = (result.phase_now == vsp_pkg::PH_HOLD);
  assign is_up   = (result.phase_now == vsp_pkg::PH_UP);
  assign is_down = (result.phase_now == vsp_pkg::PH_DOWN);
  assign both_on = result.open_enable && result.close_enable;

  // stalled tick transaction holds
  `VSP_ASSERT_NEXT(a_item_hold, item_valid && item_stall, item_valid && $stable(item))

  // stalled result transaction holds
  `VSP_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

  // both enables only during an up pulse
  `VSP_ASSERT_NOW(a_both_up, result_valid && both_on, is_up)

  // no open drive while pulsing down
  `VSP_ASSERT_NOW(a_down_closed, result_valid && is_down, !result.open_enable)

  // a refused up step leaves the phase in hold
  `VSP_ASSERT_NOW(a_refused_hold, result_valid && result.demand_reset, is_hold)

endmodule

bind valve_step_positioner vsp_checker u_vsp_checker (.*);

// ----- tb/sv/valve_step_positioner_checker.sv -----
// ----------------------------------------------------------------------------
// valve_step_positioner_checker
// Watches the tick and result channels and the register port of the valve
// step positioner. Keeps its own copy of phase, tick counter, pulse length,
// position estimate and registers. For every accepted tick it works out the
// result due and queues it. Each accepted result is compared field by field
// with the oldest queued one.
// ----------------------------------------------------------------------------
module valve_step_positioner_checker
  import vsp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_stall,
  input  item_t                      item,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  result_t                    result,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                         fail_count,
  output int                         pending,
  output int                         checked_count,
  output int                         step_count,
  output int                         refusal_count
);

  cfg_t             regs;
  phase_t           valve_phase;
  logic [15:0]      elapsed;
  logic [16:0]      pulse_len;
  logic [15:0]      position;
  result_t          expected_results[$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked_count = 0;
    step_count    = 0;
    refusal_count = 0;
  end

  task report(input string msg);
    fail_count++;
    $display("mismatch at result %0d: %s", checked_count, msg);
  endtask

  task write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                      input logic [CFG_DATA_WIDTH-1:0] data);
    case (reg_index_t'(idx))
      REG_HOLD_TIME:       regs.hold_time       = data;
      REG_UP_MIN_STEP:     regs.up_min_step     = data;
      REG_UP_MAX_STEP:     regs.up_max_step     = data;
      REG_DOWN_MIN_STEP:   regs.down_min_step   = data;
      REG_DOWN_MAX_STEP:   regs.down_max_step   = data;
      REG_UP_EXTRA_TIME:   regs.up_extra_time   = data;
      REG_DOWN_EXTRA_TIME: regs.down_extra_time = data;
      REG_MOTOR_MODE:      regs.motor_mode      = data[0];
      default: ;
    endcase
  endtask

  // one millisecond tick of the positioner
  task advance_tick(input item_t t, output result_t r);
    logic [15:0] e;
    logic [16:0] st;
    logic [16:0] wait_len;
    bit          changed;
    bit          refused;
    changed = 1'b0;
    refused = 1'b0;
    e = (elapsed != 16'hFFFF) ? elapsed + 16'd1 : elapsed;
    if (t.startup_inhibit) begin
      valve_phase = PH_DOWN;
    end else if (valve_phase == PH_HOLD) begin
      if (e >= regs.hold_time) begin
        if (t.demand_position > position &&
            t.demand_position - position > regs.up_min_step) begin
          if (t.pressure_low) begin
            refused = 1'b1;
          end else begin
            st = t.demand_position - position;
            if (st > regs.up_max_step) st = regs.up_max_step;
            valve_phase = PH_UP;
            changed = 1'b1;
            pulse_len = st + regs.up_extra_time;
            position = position + st[15:0];
          end
        end else if (position > t.demand_position &&
                     position - t.demand_position > regs.down_min_step) begin
          st = position - t.demand_position;
          if (st > regs.down_max_step) st = regs.down_max_step;
          valve_phase = PH_DOWN;
          changed = 1'b1;
          pulse_len = st + regs.down_extra_time;
          position = position - st[15:0];
        end
      end
    end else if (valve_phase == PH_UP || valve_phase == PH_DOWN) begin
      wait_len = (pulse_len > 17'h0FFFF) ? 17'h0FFFF : pulse_len;
      if ({1'b0, e} >= wait_len) begin
        valve_phase = PH_HOLD;
        changed = 1'b1;
      end
    end else begin
      valve_phase = PH_HOLD;
      changed = 1'b1;
    end
    elapsed = changed ? 16'd0 : e;
    if (changed && valve_phase != PH_HOLD) step_count++;
    if (refused) refusal_count++;
    if (regs.motor_mode) begin
      r.open_enable  = (valve_phase == PH_UP);
      r.close_enable = (valve_phase == PH_DOWN);
    end else begin
      r.open_enable  = (valve_phase != PH_DOWN);
      r.close_enable = (valve_phase == PH_UP);
    end
    r.phase_now    = valve_phase;
    r.position_now = position;
    r.demand_reset = refused;
  endtask

  task compare_result(input result_t got, input result_t want);
    if (got.open_enable !== want.open_enable)
      report($sformatf("open_enable %0b, expected %0b", got.open_enable, want.open_enable));
    if (got.close_enable !== want.close_enable)
      report($sformatf("close_enable %0b, expected %0b", got.close_enable,
                       want.close_enable));
    if (got.phase_now !== want.phase_now)
      report($sformatf("phase_now %0d, expected %0d", got.phase_now, want.phase_now));
    if (got.position_now !== want.position_now)
      report($sformatf("position_now %0d, expected %0d", got.position_now,
                       want.position_now));
    if (got.demand_reset !== want.demand_reset)
      report($sformatf("demand_reset %0b, expected %0b", got.demand_reset,
                       want.demand_reset));
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      regs        = CFG_RESET;
      valve_phase = PH_HOLD;
      elapsed     = 16'd0;
      pulse_len   = PULSE_RESET;
      position    = 16'd0;
      expected_results.delete();
    end else begin
      if (cfg_write) write_register(cfg_index, cfg_data);
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report("result transaction with no tick waiting");
        end else begin
          want = expected_results.pop_front();
          compare_result(result, want);
        end
        checked_count++;
      end
      if (item_valid && !item_stall) begin
        advance_tick(item, want);
        expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/sv/tb_valve_step_positioner.sv -----
// ----------------------------------------------------------------------------
// tb_valve_step_positioner
// Drives tick transactions and register settings into the valve step
// positioner while the checker predicts and compares every result. A short
// directed run covers refusal on low pressure, clamped up and down steps,
// start-up inhibit and the step threshold; then held setpoints with random
// content, pressure drops and inhibit bursts run under several settings,
// extremes included, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_valve_step_positioner;
  import vsp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       item_valid = 1'b0;
  logic                       item_stall;
  item_t                      item = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  result_t                    result;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  int          fail_count;
  int          pending;
  int          checked_count;
  int          step_count;
  int          refusal_count;
  int          cycle_count;
  int          tick_total = 0;
  int          setting_total = 0;
  bit          idle_on = 1'b1;
  logic [15:0] last_setpoint = 16'd0;

  always #4 clk = ~clk;

  valve_step_positioner u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  valve_step_positioner_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .step_count    (step_count),
    .refusal_count (refusal_count)
  );

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Some tests failed");
    $finish;
  end

  initial begin : result_back_pressure
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task send_tick(input item_t t);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= t;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    tick_total++;
    @(negedge clk);
  endtask

  task repeat_tick(input int n, input logic [15:0] demand, input logic plow,
                   input logic inhibit);
    item_t t;
    t.demand_position = demand;
    t.pressure_low    = plow;
    t.startup_inhibit = inhibit;
    repeat (n) send_tick(t);
  endtask

  // sender holds off until every tick has its result back
  task drain;
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_reg(input reg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task load_setting(input cfg_t c);
    drain();
    write_reg(REG_HOLD_TIME, c.hold_time);
    write_reg(REG_UP_MIN_STEP, c.up_min_step);
    write_reg(REG_UP_MAX_STEP, c.up_max_step);
    write_reg(REG_DOWN_MIN_STEP, c.down_min_step);
    write_reg(REG_DOWN_MAX_STEP, c.down_max_step);
    write_reg(REG_UP_EXTRA_TIME, c.up_extra_time);
    write_reg(REG_DOWN_EXTRA_TIME, c.down_extra_time);
    write_reg(REG_MOTOR_MODE, {15'd0, c.motor_mode});
    cfg_write <= 1'b0;
    @(negedge clk);
    setting_total++;
  endtask

  // setpoints held for random stretches, with pressure drops and inhibit
  task run_setpoints(input int n_ticks, input int span, input bit full_range,
                     input bit quiet, input int pause_at);
    int    sent;
    int    pick;
    int    run_len;
    int    inhibit_len;
    item_t t;
    sent = 0;
    while (sent < n_ticks) begin
      pick = $urandom_range(0, 9);
      if (!full_range || pick >= 8) last_setpoint = 16'($urandom_range(0, span));
      else if (pick < 4) last_setpoint = 16'($urandom);
      else last_setpoint = last_setpoint + 16'($urandom_range(0, 2 * span)) - 16'(span);
      run_len = $urandom_range(1, 40);
      inhibit_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
      for (int k = 0; k < run_len && sent < n_ticks; k++) begin
        if (sent % 40 == 0) idle_on = !quiet && ($urandom_range(0, 9) < 7);
        if (full_range && $urandom_range(0, 19) == 0) t.demand_position = 16'($urandom);
        else t.demand_position = last_setpoint;
        t.pressure_low    = ($urandom_range(0, 7) == 0);
        t.startup_inhibit = (k < inhibit_len);
        send_tick(t);
        sent++;
        if (sent == pause_at) drain();
      end
    end
  endtask

  initial begin : stimulus
    cfg_t c;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset setting: long hold, no step is taken yet, then an inhibit tick
    repeat_tick(2, 16'hFFFF, 1'b0, 1'b0);
    repeat_tick(1, 16'h0000, 1'b1, 1'b1);

    c = '{hold_time: 16'd2, up_min_step: 16'd5, up_max_step: 16'd8,
          down_min_step: 16'd6, down_max_step: 16'd7, up_extra_time: 16'd1,
          down_extra_time: 16'd2, motor_mode: 1'b0};
    load_setting(c);
    repeat_tick(1, 16'h0000, 1'b0, 1'b0);
    repeat_tick(2, 16'hFFFF, 1'b1, 1'b0);
    repeat_tick(11, 16'hFFFF, 1'b0, 1'b0);
    repeat_tick(3, 16'h0000, 1'b0, 1'b0);
    repeat_tick(2, 16'h0000, 1'b0, 1'b1);
    repeat_tick(3, 16'h0005, 1'b0, 1'b0);

    // low extremes, unclamped steps, motor drive
    c = '{hold_time: 16'd0, up_min_step: 16'd0, up_max_step: 16'hFFFF,
          down_min_step: 16'd0, down_max_step: 16'hFFFF, up_extra_time: 16'd0,
          down_extra_time: 16'd0, motor_mode: 1'b1};
    load_setting(c);
    run_setpoints(150, 300, 1'b0, 1'b0, 0);

    // high extremes, no step can start
    c = '{hold_time: 16'hFFFF, up_min_step: 16'hFFFF, up_max_step: 16'hFFFF,
          down_min_step: 16'hFFFF, down_max_step: 16'hFFFF,
          up_extra_time: 16'hFFFF, down_extra_time: 16'hFFFF, motor_mode: 1'b0};
    load_setting(c);
    run_setpoints(60, 300, 1'b1, 1'b0, 0);

    // zero step clamp, pulses of extra time only
    c = '{hold_time: 16'd4, up_min_step: 16'd20, up_max_step: 16'd0,
          down_min_step: 16'd20, down_max_step: 16'd0, up_extra_time: 16'd6,
          down_extra_time: 16'd9, motor_mode: 1'b1};
    load_setting(c);
    run_setpoints(80, 300, 1'b1, 1'b0, 0);

    c = '{hold_time: 16'd10, up_min_step: 16'd50, up_max_step: 16'd60,
          down_min_step: 16'd40, down_max_step: 16'd50, up_extra_time: 16'd5,
          down_extra_time: 16'd5, motor_mode: 1'b0};
    load_setting(c);
    run_setpoints(200, 200, 1'b1, 1'b0, 100);

    for (int r = 0; r < 3; r++) begin
      c.hold_time       = 16'($urandom_range(0, 15));
      c.up_min_step     = 16'($urandom_range(0, 40));
      c.up_max_step     = 16'($urandom_range(1, 80));
      c.down_min_step   = 16'($urandom_range(0, 40));
      c.down_max_step   = 16'($urandom_range(1, 80));
      c.up_extra_time   = 16'($urandom_range(0, 10));
      c.down_extra_time = 16'($urandom_range(0, 10));
      c.motor_mode      = 1'($urandom_range(0, 1));
      load_setting(c);
      run_setpoints(140, 200, 1'b1, r == 2, 0);
    end

    drain();
    $display("sent %0d ticks under %0d register settings, %0d results checked",
             tick_total, setting_total, checked_count);
    $display("%0d valve steps taken, %0d up steps refused on low pressure",
             step_count, refusal_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/vsp_pkg.sv
sv/vsp_step.sv
sv/valve_step_positioner.sv
sv/vsp_checker.sv
tb/sv/valve_step_positioner_checker.sv
tb/sv/tb_valve_step_positioner.sv
